/* hw/rtl/ews_pkg.sv */
// Shared types, constants and matcher functions of the encoded word splitter.
package ews_pkg;

   // Default width of the internal byte offset counters.
   localparam int OFFSET_BITS_DEFAULT = 16;

   // Number of result records the output queue holds (a power of two, at least 2).
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Width of every offset and length field in a result record.
   localparam int FIELD_BITS = 16;

   // Characters that the matcher looks for.
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_LOWER_B  = 8'h62;
   localparam logic [7:0] CH_LOWER_Q  = 8'h71;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   // Chunk kinds and coding letters as they appear in a record.
   localparam logic KIND_RAW     = 1'b0;
   localparam logic KIND_ENCODED = 1'b1;
   localparam logic CODING_B     = 1'b0;
   localparam logic CODING_Q     = 1'b1;

   // Byte classes seen by the matcher.
   typedef enum logic [1:0] {
      TK_EQ     = 2'd0,
      TK_QM     = 2'd1,
      TK_OTHER  = 2'd2,
      TK_LETTER = 2'd3
   } tok_type;

   // Matcher states, one-hot.
   typedef enum logic [7:0] {
      MS_START    = 8'b0000_0001,  // nothing matched
      MS_EQ       = 8'b0000_0010,  // seen "="
      MS_OPEN     = 8'b0000_0100,  // seen "=?"
      MS_CHARSET  = 8'b0000_1000,  // inside the charset
      MS_CS_END   = 8'b0001_0000,  // seen the "?" after the charset
      MS_LETTER   = 8'b0010_0000,  // seen the encoding letter
      MS_DATA     = 8'b0100_0000,  // inside the data
      MS_DATA_QM  = 8'b1000_0000   // seen the "?" that may close the word
   } ms_type;

   // Outcome of one matcher step.
   typedef struct packed {
      logic   fail;
      logic   done;
      ms_type next;
   } step_type;

   // One result record.
   typedef struct packed {
      logic                  chunk_kind;
      logic                  coding;
      logic [FIELD_BITS-1:0] charset_start;
      logic [FIELD_BITS-1:0] charset_length;
      logic [FIELD_BITS-1:0] payload_start;
      logic [FIELD_BITS-1:0] payload_length;
      logic                  final_chunk;
      logic                  too_long;
   } record_type;

   // Push flags from the record builder to the queue.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // Sort a byte into the classes the matcher distinguishes.
   function automatic tok_type classify(logic [7:0] ch);
      tok_type t;
      if (ch == CH_QUESTION) begin
         t = TK_QM;
      end else if (ch == CH_EQUALS) begin
         t = TK_EQ;
      end else if ((ch | CASE_BIT) == CH_LOWER_B || (ch | CASE_BIT) == CH_LOWER_Q) begin
         t = TK_LETTER;
      end else begin
         t = TK_OTHER;
      end
      return t;
   endfunction

   // One step of the encoded word syntax.
   function automatic step_type advance(ms_type s, tok_type t);
      step_type r;
      r.fail = 1'b0;
      r.done = 1'b0;
      r.next = MS_START;
      case (s)
         MS_START: begin
            r.next = (t == TK_EQ) ? MS_EQ : MS_START;
         end
         MS_EQ: begin
            if (t == TK_QM) r.next = MS_OPEN;
            else r.fail = 1'b1;
         end
         MS_OPEN: begin
            if (t == TK_EQ || t == TK_QM) r.fail = 1'b1;
            else r.next = MS_CHARSET;
         end
         MS_CHARSET: begin
            if (t == TK_QM) r.next = MS_CS_END;
            else if (t == TK_EQ) r.fail = 1'b1;
            else r.next = MS_CHARSET;
         end
         MS_CS_END: begin
            if (t == TK_LETTER) r.next = MS_LETTER;
            else r.fail = 1'b1;
         end
         MS_LETTER: begin
            if (t == TK_QM) r.next = MS_DATA;
            else r.fail = 1'b1;
         end
         MS_DATA: begin
            r.next = (t == TK_QM) ? MS_DATA_QM : MS_DATA;
         end
         MS_DATA_QM: begin
            if (t == TK_EQ) r.done = 1'b1;
            else r.fail = 1'b1;
         end
         default: begin
            r.next = MS_START;
         end
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/ews_result_queue.sv */
// Small register queue that holds result records until the receiver takes them.
module ews_result_queue #(
   parameter int DEPTH = ews_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ews_pkg::push_type   push,
   input  ews_pkg::record_type push_rec0,
   input  ews_pkg::record_type push_rec1,
   output logic                no_room,
   output logic                head_valid,
   input  logic                head_stall,
   output ews_pkg::record_type head_rec
);

   localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);

   ews_pkg::record_type entries [DEPTH];

   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_second;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 pop;

   // The head record leaves when the receiver does not stall it.
   assign head_valid = (count_ff != '0);
   assign head_rec   = entries[rd_ptr_ff];
   assign pop        = head_valid & ~head_stall;

   // A request can push two records, so keep two slots free.
   assign no_room = (count_ff > CountBits'(DEPTH - 2));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_second = PtrBits'(wr_ptr_ff + 1'b1);
      wr_ptr_in     = PtrBits'(wr_ptr_ff + PtrBits'(push.first) + PtrBits'(push.second));
      rd_ptr_in     = PtrBits'(rd_ptr_ff + PtrBits'(pop));
      count_in      = CountBits'(count_ff + CountBits'(push.first)
                                 + CountBits'(push.second) - CountBits'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage; the second record goes into the slot after the first.
   always_ff @(posedge clock) begin
      if (push.first) begin
         entries[wr_ptr_ff] <= push_rec0;
      end
      if (push.second) begin
         entries[wr_ptr_second] <= push_rec1;
      end
   end

endmodule

/* hw/rtl/encoded_word_splitter_unit.sv */
// Top level of the encoded word splitter: matcher, offset registers and result queue.
//
//   channel   direction  accepted when            carries
//   req_*     in         req_valid & !req_stall   one header byte, end-of-text flag
//   rsp_*     out        rsp_valid & !rsp_stall   one raw or encoded chunk record
//
// One request is taken per cycle while the result queue has two free slots.
// The matcher step and record build are combinational from the state registers
// into the queue, so a record can be offered the cycle after its request when the queue is empty.
// A closing "?=" pushes two records, which leave one after the other.
// Reset clears the matcher, the offsets and the queue.
// rsp_stall holds the head record; req_stall rises when fewer than two slots are free.
module encoded_word_splitter_unit #(
   parameter int OFFSET_BITS = ews_pkg::OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ews_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_chunk_kind,
   output logic                          rsp_coding,
   output logic [ews_pkg::FIELD_BITS-1:0] rsp_charset_start,
   output logic [ews_pkg::FIELD_BITS-1:0] rsp_charset_length,
   output logic [ews_pkg::FIELD_BITS-1:0] rsp_payload_start,
   output logic [ews_pkg::FIELD_BITS-1:0] rsp_payload_length,
   output logic                          rsp_final_chunk,
   output logic                          rsp_too_long
);

   localparam logic [OFFSET_BITS-1:0] OfsMax = '1;
   localparam int WideBits = (OFFSET_BITS > ews_pkg::FIELD_BITS) ?
                             OFFSET_BITS : ews_pkg::FIELD_BITS;

   // Offset increment that sticks at the top value.
   function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] v);
      return (v == OfsMax) ? v : OFFSET_BITS'(v + 1'b1);
   endfunction

   // Subtraction that stops at zero.
   function automatic logic [OFFSET_BITS-1:0] sat_sub(logic [OFFSET_BITS-1:0] a,
                                                      logic [OFFSET_BITS-1:0] b);
      return (a > b) ? OFFSET_BITS'(a - b) : '0;
   endfunction

   // Low bits of an offset as a record field, zero-extended when the offset is narrow.
   function automatic logic [ews_pkg::FIELD_BITS-1:0] to_field(logic [OFFSET_BITS-1:0] v);
      logic [WideBits-1:0] w;
      w = WideBits'(v);
      return w[ews_pkg::FIELD_BITS-1:0];
   endfunction

   ews_pkg::ms_type         state_ff, state_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]  charset_begin_ff, charset_begin_in;
   logic [OFFSET_BITS-1:0]  coding_offset_ff, coding_offset_in;
   logic [OFFSET_BITS-1:0]  data_mark_ff, data_mark_in;
   logic [OFFSET_BITS-1:0]  raw_begin_ff, raw_begin_in;
   logic                    overflowed_ff, overflowed_in;
   logic                    coding_bit_ff, coding_bit_in;

   logic                    req_fire;
   logic                    ovf_now;
   ews_pkg::tok_type        tok;
   ews_pkg::step_type       step;
   ews_pkg::ms_type         ns;
   ews_pkg::push_type       push;
   ews_pkg::record_type     rec0, rec1, head_rec;

   assign req_fire = req_valid & ~req_stall;

   // Matcher step, offset bookkeeping and record build for one request.
   always_comb begin
      state_in         = state_ff;
      offset_in        = offset_ff;
      charset_begin_in = charset_begin_ff;
      coding_offset_in = coding_offset_ff;
      data_mark_in     = data_mark_ff;
      raw_begin_in     = raw_begin_ff;
      overflowed_in    = overflowed_ff;
      coding_bit_in    = coding_bit_ff;
      push             = '0;

      ovf_now = overflowed_ff | (offset_ff == OfsMax);
      tok     = ews_pkg::classify(req_text_byte);
      step    = ews_pkg::advance(state_ff, tok);
      // A byte that breaks a partial match is looked at again from the start.
      if (step.fail) begin
         step = ews_pkg::advance(ews_pkg::MS_START, tok);
      end
      ns = step.next;

      // Raw chunk ahead of a word, or the trailing raw chunk at end of text.
      rec0.chunk_kind     = ews_pkg::KIND_RAW;
      rec0.coding         = ews_pkg::CODING_B;
      rec0.charset_start  = '0;
      rec0.charset_length = '0;
      rec0.payload_start  = to_field(raw_begin_ff);
      rec0.payload_length = to_field(sat_sub(sat_inc(offset_ff), raw_begin_ff));
      rec0.final_chunk    = 1'b1;
      rec0.too_long       = ovf_now;

      // Encoded word chunk.
      rec1.chunk_kind     = ews_pkg::KIND_ENCODED;
      rec1.coding         = coding_bit_ff;
      rec1.charset_start  = to_field(charset_begin_ff);
      rec1.charset_length = to_field(sat_sub(sat_sub(coding_offset_ff, OFFSET_BITS'(1)),
                                             charset_begin_ff));
      rec1.payload_start  = to_field(data_mark_ff);
      rec1.payload_length = to_field(sat_sub(sat_sub(offset_ff, OFFSET_BITS'(1)),
                                             data_mark_ff));
      rec1.final_chunk    = req_end_of_text;
      rec1.too_long       = ovf_now;

      if (req_fire) begin
         overflowed_in = ovf_now;

         // Remember where the charset, the letter and the data begin.
         if (ns == ews_pkg::MS_OPEN && state_ff == ews_pkg::MS_EQ) begin
            charset_begin_in = sat_inc(offset_ff);
         end
         if (ns == ews_pkg::MS_CS_END && state_ff == ews_pkg::MS_CHARSET) begin
            coding_offset_in = sat_inc(offset_ff);
         end
         if (ns == ews_pkg::MS_LETTER) begin
            coding_bit_in = ((req_text_byte | ews_pkg::CASE_BIT) == ews_pkg::CH_LOWER_Q) ?
                            ews_pkg::CODING_Q : ews_pkg::CODING_B;
         end
         if (ns == ews_pkg::MS_DATA && state_ff == ews_pkg::MS_LETTER) begin
            data_mark_in = sat_inc(offset_ff);
         end

         if (step.done) begin
            // Closing "?=": the raw text before the word, then the word itself.
            rec0.payload_length = to_field(sat_sub(sat_sub(charset_begin_ff,
                                                           OFFSET_BITS'(2)), raw_begin_ff));
            rec0.final_chunk    = 1'b0;
            push.first          = 1'b1;
            push.second         = 1'b1;
            raw_begin_in        = sat_inc(offset_ff);
            state_in            = ews_pkg::MS_START;
         end else begin
            state_in = ns;
         end

         offset_in = sat_inc(offset_ff);

         // End of text: report what is left and start over for the next string.
         if (req_end_of_text) begin
            if (!step.done) begin
               push.first = 1'b1;
            end
            state_in         = ews_pkg::MS_START;
            offset_in        = '0;
            charset_begin_in = '0;
            coding_offset_in = '0;
            data_mark_in     = '0;
            raw_begin_in     = '0;
            overflowed_in    = 1'b0;
            coding_bit_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ews_pkg::MS_START;
         offset_ff        <= '0;
         charset_begin_ff <= '0;
         coding_offset_ff <= '0;
         data_mark_ff     <= '0;
         raw_begin_ff     <= '0;
         overflowed_ff    <= 1'b0;
         coding_bit_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         offset_ff        <= offset_in;
         charset_begin_ff <= charset_begin_in;
         coding_offset_ff <= coding_offset_in;
         data_mark_ff     <= data_mark_in;
         raw_begin_ff     <= raw_begin_in;
         overflowed_ff    <= overflowed_in;
         coding_bit_ff    <= coding_bit_in;
      end
   end

   // Result queue between the record builder and the response channel.
   ews_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec0  (rec0),
      .push_rec1  (rec1),
      .no_room    (req_stall),
      .head_valid (rsp_valid),
      .head_stall (rsp_stall),
      .head_rec   (head_rec)
   );

   // Response fields from the head record.
   assign rsp_chunk_kind     = head_rec.chunk_kind;
   assign rsp_coding         = head_rec.coding;
   assign rsp_charset_start  = head_rec.charset_start;
   assign rsp_charset_length = head_rec.charset_length;
   assign rsp_payload_start  = head_rec.payload_start;
   assign rsp_payload_length = head_rec.payload_length;
   assign rsp_final_chunk    = head_rec.final_chunk;
   assign rsp_too_long       = head_rec.too_long;

endmodule

/* hw/rtl/ews_checker.sv */
// Port-level checks of the encoded word splitter and their attachment to the top level.
module ews_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [7:0]                     req_text_byte,
   input logic                           req_end_of_text,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_chunk_kind,
   input logic                           rsp_coding,
   input logic [ews_pkg::FIELD_BITS-1:0] rsp_charset_start,
   input logic [ews_pkg::FIELD_BITS-1:0] rsp_charset_length,
   input logic [ews_pkg::FIELD_BITS-1:0] rsp_payload_start,
   input logic [ews_pkg::FIELD_BITS-1:0] rsp_payload_length,
   input logic                           rsp_final_chunk,
   input logic                           rsp_too_long
);

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled request keeps its byte and end flag.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_text_byte)
         && $stable(req_end_of_text))
      else $error("stalled request changed");

   // A stalled response keeps its record.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chunk_kind) && $stable(rsp_coding)
         && $stable(rsp_charset_start) && $stable(rsp_charset_length)
         && $stable(rsp_payload_start) && $stable(rsp_payload_length)
         && $stable(rsp_final_chunk) && $stable(rsp_too_long))
      else $error("stalled response changed");

   // Raw chunks carry no coding letter and no charset.
   a_raw_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chunk_kind == ews_pkg::KIND_RAW |->
         rsp_coding == ews_pkg::CODING_B && rsp_charset_start == '0
         && rsp_charset_length == '0)
      else $error("raw chunk with charset or coding");

   // With nothing queued there is room for the next request.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while no response pending");

endmodule

bind encoded_word_splitter_unit ews_checker u_checker (.*);

/* bench/encoded_word_splitter_unit_test.sv */
// Self-checking testbench for the encoded word splitter: header text in, chunk records out.
module encoded_word_splitter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] text_type[$];
   typedef logic [ews_pkg::FIELD_BITS-1:0] field_type;

   // Predicts the chunk records of a header string and checks the ones the block returns.
   class chunk_scoreboard;
      localparam int unsigned OFFSET_LIMIT = (32'd1 << ews_pkg::OFFSET_BITS_DEFAULT) - 1;

      ews_pkg::record_type expected_chunks[$];
      int unsigned failures = 0;
      int unsigned chunks_checked = 0;
      int unsigned words_checked = 0;
      int unsigned long_checked = 0;

      // Matcher state and the offsets it records.
      ews_pkg::ms_type word_state = ews_pkg::MS_START;
      int unsigned next_offset = 0;
      int unsigned charset_from = 0;
      int unsigned letter_at = 0;
      int unsigned data_from = 0;
      int unsigned raw_from = 0;
      logic        overflowed = 1'b0;
      logic        q_letter = 1'b0;

      function int unsigned bump(int unsigned v);
         return (v >= OFFSET_LIMIT) ? OFFSET_LIMIT : v + 1;
      endfunction

      function int unsigned less(int unsigned a, int unsigned b);
         return (a > b) ? a - b : 0;
      endfunction

      function ews_pkg::tok_type byte_class(logic [7:0] ch);
         ews_pkg::tok_type t;
         t = ews_pkg::TK_OTHER;
         if (ch == ews_pkg::CH_QUESTION) begin
            t = ews_pkg::TK_QM;
         end else if (ch == ews_pkg::CH_EQUALS) begin
            t = ews_pkg::TK_EQ;
         end else if (ch == "B" || ch == "b" || ch == "Q" || ch == "q") begin
            t = ews_pkg::TK_LETTER;
         end
         return t;
      endfunction

      // One step through the word syntax; broke flags a failed partial match.
      function ews_pkg::ms_type follow(ews_pkg::ms_type s, ews_pkg::tok_type t,
                                       output logic broke, output logic closed);
         ews_pkg::ms_type n;
         n = ews_pkg::MS_START;
         broke = 1'b0;
         closed = 1'b0;
         case (s)
            ews_pkg::MS_START: begin
               if (t == ews_pkg::TK_EQ) n = ews_pkg::MS_EQ;
            end
            ews_pkg::MS_EQ: begin
               if (t == ews_pkg::TK_QM) n = ews_pkg::MS_OPEN;
               else broke = 1'b1;
            end
            ews_pkg::MS_OPEN: begin
               if (t == ews_pkg::TK_EQ || t == ews_pkg::TK_QM) broke = 1'b1;
               else n = ews_pkg::MS_CHARSET;
            end
            ews_pkg::MS_CHARSET: begin
               if (t == ews_pkg::TK_QM) n = ews_pkg::MS_CS_END;
               else if (t == ews_pkg::TK_EQ) broke = 1'b1;
               else n = ews_pkg::MS_CHARSET;
            end
            ews_pkg::MS_CS_END: begin
               if (t == ews_pkg::TK_LETTER) n = ews_pkg::MS_LETTER;
               else broke = 1'b1;
            end
            ews_pkg::MS_LETTER: begin
               if (t == ews_pkg::TK_QM) n = ews_pkg::MS_DATA;
               else broke = 1'b1;
            end
            ews_pkg::MS_DATA: begin
               if (t == ews_pkg::TK_QM) n = ews_pkg::MS_DATA_QM;
               else n = ews_pkg::MS_DATA;
            end
            ews_pkg::MS_DATA_QM: begin
               if (t == ews_pkg::TK_EQ) closed = 1'b1;
               else broke = 1'b1;
            end
            default: begin
               n = ews_pkg::MS_START;
            end
         endcase
         return n;
      endfunction

      function void add_chunk(logic kind, logic cod, int unsigned cs, int unsigned cl,
                              int unsigned ps, int unsigned pl, logic fin);
         ews_pkg::record_type r;
         r.chunk_kind     = kind;
         r.coding         = cod;
         r.charset_start  = cs[ews_pkg::FIELD_BITS-1:0];
         r.charset_length = cl[ews_pkg::FIELD_BITS-1:0];
         r.payload_start  = ps[ews_pkg::FIELD_BITS-1:0];
         r.payload_length = pl[ews_pkg::FIELD_BITS-1:0];
         r.final_chunk    = fin;
         r.too_long       = overflowed;
         expected_chunks.push_back(r);
      endfunction

      // Called for every accepted request: advances the matcher and queues its records.
      function void note_byte(logic [7:0] ch, logic last);
         int unsigned      p;
         ews_pkg::tok_type t;
         ews_pkg::ms_type  ns;
         logic             broke;
         logic             closed;
         p = next_offset;
         t = byte_class(ch);
         if (p >= OFFSET_LIMIT) overflowed = 1'b1;

         // A byte that breaks a partial match is looked at again from the start.
         ns = follow(word_state, t, broke, closed);
         if (broke) ns = follow(ews_pkg::MS_START, t, broke, closed);

         if (ns == ews_pkg::MS_OPEN && word_state == ews_pkg::MS_EQ) charset_from = bump(p);
         if (ns == ews_pkg::MS_CS_END && word_state == ews_pkg::MS_CHARSET) begin
            letter_at = bump(p);
         end
         if (ns == ews_pkg::MS_LETTER) q_letter = (ch == "Q" || ch == "q");
         if (ns == ews_pkg::MS_DATA && word_state == ews_pkg::MS_LETTER) data_from = bump(p);

         if (closed) begin
            add_chunk(ews_pkg::KIND_RAW, ews_pkg::CODING_B, 0, 0, raw_from,
                      less(less(charset_from, 2), raw_from), 1'b0);
            add_chunk(ews_pkg::KIND_ENCODED, q_letter ? ews_pkg::CODING_Q : ews_pkg::CODING_B,
                      charset_from, less(less(letter_at, 1), charset_from), data_from,
                      less(less(p, 1), data_from), last);
            raw_from = bump(p);
            word_state = ews_pkg::MS_START;
         end else begin
            word_state = ns;
         end
         next_offset = bump(p);

         // The last byte flushes leftover raw text and clears everything for the next string.
         if (last) begin
            if (!closed) begin
               add_chunk(ews_pkg::KIND_RAW, ews_pkg::CODING_B, 0, 0, raw_from,
                         less(bump(p), raw_from), 1'b1);
            end
            word_state = ews_pkg::MS_START;
            next_offset = 0;
            charset_from = 0;
            letter_at = 0;
            data_from = 0;
            raw_from = 0;
            overflowed = 1'b0;
            q_letter = 1'b0;
         end
      endfunction

      function void compare(string field, field_type want, field_type got);
         if (got !== want) begin
            $error("chunk field %s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      // Called for every accepted response.
      function void check_chunk(ews_pkg::record_type got);
         ews_pkg::record_type want;
         if (expected_chunks.size() == 0) begin
            $error("chunk record returned with none expected (kind %0d, start %0d)",
                   got.chunk_kind, got.payload_start);
            failures++;
            return;
         end
         want = expected_chunks.pop_front();
         compare("chunk_kind", field_type'(want.chunk_kind), field_type'(got.chunk_kind));
         compare("coding", field_type'(want.coding), field_type'(got.coding));
         compare("charset_start", want.charset_start, got.charset_start);
         compare("charset_length", want.charset_length, got.charset_length);
         compare("payload_start", want.payload_start, got.payload_start);
         compare("payload_length", want.payload_length, got.payload_length);
         compare("final_chunk", field_type'(want.final_chunk), field_type'(got.final_chunk));
         compare("too_long", field_type'(want.too_long), field_type'(got.too_long));
         chunks_checked++;
         if (want.chunk_kind == ews_pkg::KIND_ENCODED) words_checked++;
         if (want.too_long) long_checked++;
      endfunction

      function int unsigned pending();
         return expected_chunks.size();
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_BYTES = 130;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic      req_end_of_text = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_chunk_kind;
   logic      rsp_coding;
   field_type rsp_charset_start;
   field_type rsp_charset_length;
   field_type rsp_payload_start;
   field_type rsp_payload_length;
   logic      rsp_final_chunk;
   logic      rsp_too_long;

   chunk_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_taken = 0;
   int unsigned hold_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned send_mix[4] = '{0, 58, 0, 26};
   int unsigned stall_mix[4] = '{0, 0, 58, 26};

   encoded_word_splitter_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_chunk_kind     (rsp_chunk_kind),
      .rsp_coding         (rsp_coding),
      .rsp_charset_start  (rsp_charset_start),
      .rsp_charset_length (rsp_charset_length),
      .rsp_payload_start  (rsp_payload_start),
      .rsp_payload_length (rsp_payload_length),
      .rsp_final_chunk    (rsp_final_chunk),
      .rsp_too_long       (rsp_too_long)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: check accepted records, then pick the stall for the next cycle.
   always @(posedge clock) begin : response_side
      ews_pkg::record_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.chunk_kind     = rsp_chunk_kind;
         got.coding         = rsp_coding;
         got.charset_start  = rsp_charset_start;
         got.charset_length = rsp_charset_length;
         got.payload_start  = rsp_payload_start;
         got.payload_length = rsp_payload_length;
         got.final_chunk    = rsp_final_chunk;
         got.too_long       = rsp_too_long;
         sb.check_chunk(got);
      end
      // A long hold-off lets the output queue fill and push back on requests.
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
   task automatic send_byte(input logic [7:0] ch, input logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= ch;
      req_end_of_text <= last;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_byte(ch, last);
      bytes_sent++;
   endtask

   task automatic send_text(input text_type text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   function automatic text_type from_ascii(string s);
      text_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      return text;
   endfunction

   function automatic logic [7:0] byte_without(logic no_equals);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == ews_pkg::CH_QUESTION || (no_equals && b == ews_pkg::CH_EQUALS));
      return b;
   endfunction

   // Append a well-formed encoded word with random charset, letter and data.
   function automatic void add_word(ref text_type text);
      int unsigned n;
      text.push_back(ews_pkg::CH_EQUALS);
      text.push_back(ews_pkg::CH_QUESTION);
      n = $urandom_range(1, 4);
      repeat (n) text.push_back(byte_without(1'b1));
      text.push_back(ews_pkg::CH_QUESTION);
      case ($urandom_range(3))
         0: text.push_back("B");
         1: text.push_back("b");
         2: text.push_back("Q");
         default: text.push_back("q");
      endcase
      text.push_back(ews_pkg::CH_QUESTION);
      n = $urandom_range(0, 5);
      repeat (n) text.push_back(byte_without(1'b0));
      text.push_back(ews_pkg::CH_QUESTION);
      text.push_back(ews_pkg::CH_EQUALS);
   endfunction

   // Build and send one header string of well-formed words, optionally mixed with noise.
   task automatic send_header(input logic words_only);
      text_type    text;
      text_type    part;
      int unsigned pieces;
      int unsigned pick;
      int unsigned n;
      pieces = $urandom_range(1, 4);
      repeat (pieces) begin
         pick = words_only ? 0 : $urandom_range(9);
         if (pick < 5) begin
            add_word(text);
         end else if (pick < 7) begin
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(8'($urandom_range(255)));
         end else if (pick < 9) begin
            // A word cut short and followed by a random byte.
            part.delete();
            add_word(part);
            n = $urandom_range(1, part.size() - 1);
            for (int i = 0; i < n; i++) text.push_back(part[i]);
            text.push_back(8'($urandom_range(255)));
         end else begin
            text.push_back(($urandom_range(1) != 0) ? ews_pkg::CH_EQUALS : ews_pkg::CH_QUESTION);
         end
      end
      send_text(text);
   endtask

   // Stop offering requests and wait until every expected record has come back.
   task automatic wait_for_chunks();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.pending() != 0);
   endtask

   // Main sequence: reset, directed strings, then random phases.
   initial begin : stimulus
      text_type    text;
      int unsigned phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme bytes, a word on the last byte with empty data, a restart on
      // a second '=', '=' inside data, raw text after a word, and a partial match at the end.
      text.push_back(8'hFF);
      send_text(text);
      send_text(from_ascii("=?a?B??="));
      text = from_ascii("==?c?q?d=?=");
      text.push_back(8'h00);
      send_text(text);
      send_text(from_ascii("=?b?Q"));
      wait_for_chunks();

      // Random phases with different mixes of request gaps and response stalls.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_mix[ph];
         stall_pct = stall_mix[ph];
         if (ph == 0) begin
            hold_asked++;
            repeat (6) send_header(1'b1);
            wait_for_chunks();
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) send_header(1'b0);
         wait_for_chunks();
      end
      stall_pct = 0;
      wait_for_chunks();
      repeat (8) @(posedge clock);

      $display("Sent %0d header bytes: directed strings, a long hold-off, four gap mixes.",
               bytes_sent);
      $display("Checked %0d records: %0d encoded words, %0d flagged too long.",
               sb.chunks_checked, sb.words_checked, sb.long_checked);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
